/* rtl/bomut_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bomut_pkg;

  // detected text encoding, as reported on the result side
  typedef enum logic [1:0] {
    ENC_ANSI    = 2'd0,
    ENC_UTF8    = 2'd1,
    ENC_UTF16LE = 2'd2,
    ENC_UTF16BE = 2'd3
  } enc_t;

  // progress through the byte order mark
  typedef enum logic [1:0] {
    BOM_START  = 2'd0,
    BOM_HELD   = 2'd1,
    BOM_EFBB   = 2'd2,
    BOM_STREAM = 2'd3
  } bom_phase_t;

  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;

  localparam int CpWidth  = 21;
  localparam int QueueLen = 2;

  // utf-8 encoding of one code point, at most three bytes
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } code_t;

  // all results caused by one request, queued between front and back
  typedef struct packed {
    logic [1:0]      cnt;    // number of results, 1 to 3
    logic [2:0][7:0] bytes;  // output bytes in order
    logic            fin;    // last result stops the stream
    logic            err;    // stop is an error
    enc_t            enc;
  } plan_t;

  function automatic code_t utf8_encode(input logic [CpWidth-1:0] cp);
    code_t c;
    c = '0;
    if (cp < 21'h80) begin
      c.cnt      = 2'd1;
      c.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      c.cnt      = 2'd2;
      c.bytes[0] = {2'b11, cp[11:6]};
      c.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      // above 0xFFFF only the low 16 bits survive
      c.cnt      = 2'd3;
      c.bytes[0] = {4'hE, cp[15:12]};
      c.bytes[1] = {2'b10, cp[11:6]};
      c.bytes[2] = {2'b10, cp[5:0]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/bomut_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module bomut_front
  import bomut_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire logic  [7:0] in_byte,
  input  wire logic  end_of_input,
  output logic       push,
  output plan_t      plan
);

  bom_phase_t           phase, phase_next;
  enc_t                 enc, enc_next;
  logic [1:0]           rem, rem_next;
  logic [CpWidth-1:0]   acc, acc_next;
  logic [7:0]           saved, saved_next;
  logic                 stopped;

  logic is_mark, pair_le, pair_be, pair_ef;
  logic [CpWidth-1:0] acc_step;
  logic [1:0] rem_dec;
  code_t code_u8, code_le, code_be;

  // mark recognition
  assign is_mark = (in_byte == BYTE_FF) || (in_byte == BYTE_FE) || (in_byte == BYTE_EF);
  assign pair_le = (saved == BYTE_FF) && (in_byte == BYTE_FE);
  assign pair_be = (saved == BYTE_FE) && (in_byte == BYTE_FF);
  assign pair_ef = (saved == BYTE_EF) && (in_byte == BYTE_BB);

  // code point assembly
  assign acc_step = {acc[CpWidth-7:0], in_byte[5:0]};
  assign rem_dec  = rem - 2'd1;
  assign code_u8  = utf8_encode(acc_step);
  assign code_le  = utf8_encode({5'd0, in_byte, saved});
  assign code_be  = utf8_encode({5'd0, saved, in_byte});

  // next mark phase
  always_comb begin
    phase_next = phase;
    if (!end_of_input) begin
      case (phase)
        BOM_START: phase_next = is_mark ? BOM_HELD : BOM_STREAM;
        BOM_HELD:  phase_next = pair_ef ? BOM_EFBB : BOM_STREAM;
        BOM_EFBB:  phase_next = BOM_STREAM;
        default:   phase_next = phase;
      endcase
    end
  end

  // results and datapath updates
  always_comb begin
    plan       = '0;
    enc_next   = enc;
    rem_next   = rem;
    acc_next   = acc;
    saved_next = saved;
    case (phase)
      BOM_START: begin
        if (end_of_input) begin
          plan.cnt = 2'd1;
          plan.fin = 1'b1;
        end else if (is_mark) begin
          saved_next = in_byte;
        end else begin
          plan.cnt      = 2'd1;
          plan.bytes[0] = in_byte;
        end
      end
      BOM_HELD: begin
        if (end_of_input) begin
          plan.cnt      = 2'd2;
          plan.bytes[0] = saved;
          plan.fin      = 1'b1;
        end else if (pair_le) begin
          enc_next = ENC_UTF16LE;
        end else if (pair_be) begin
          enc_next = ENC_UTF16BE;
        end else if (!pair_ef) begin
          plan.cnt      = 2'd2;
          plan.bytes[0] = saved;
          plan.bytes[1] = in_byte;
        end
      end
      BOM_EFBB: begin
        if (end_of_input) begin
          plan.cnt      = 2'd2;
          plan.bytes[0] = BYTE_EF;
          plan.fin      = 1'b1;
        end else if (in_byte == BYTE_BF) begin
          enc_next = ENC_UTF8;
        end else begin
          plan.cnt      = 2'd1;
          plan.bytes[0] = BYTE_EF;
        end
      end
      default: begin
        if (end_of_input) begin
          plan.cnt = 2'd1;
          plan.fin = 1'b1;
          plan.err = (rem != 2'd0);
        end else begin
          case (enc)
            ENC_ANSI: begin
              plan.cnt      = 2'd1;
              plan.bytes[0] = in_byte;
            end
            ENC_UTF8: begin
              if (rem == 2'd0) begin
                if (!in_byte[7]) begin
                  plan.cnt      = 2'd1;
                  plan.bytes[0] = in_byte;
                end else if (!in_byte[6]) begin
                  plan.cnt = 2'd1;
                  plan.fin = 1'b1;
                  plan.err = 1'b1;
                end else if (!in_byte[5]) begin
                  acc_next = {16'd0, in_byte[4:0]};
                  rem_next = 2'd1;
                end else if (!in_byte[4]) begin
                  acc_next = {17'd0, in_byte[3:0]};
                  rem_next = 2'd2;
                end else if (!in_byte[3]) begin
                  acc_next = {18'd0, in_byte[2:0]};
                  rem_next = 2'd3;
                end else begin
                  plan.cnt = 2'd1;
                  plan.fin = 1'b1;
                  plan.err = 1'b1;
                end
              end else begin
                acc_next = acc_step;
                rem_next = rem_dec;
                if (rem_dec == 2'd0) begin
                  plan.cnt   = code_u8.cnt;
                  plan.bytes = code_u8.bytes;
                end
              end
            end
            default: begin
              // utf-16: first byte of a unit is held
              if (rem == 2'd0) begin
                saved_next = in_byte;
                rem_next   = 2'd1;
              end else begin
                rem_next = 2'd0;
                if (enc == ENC_UTF16LE) begin
                  plan.cnt   = code_le.cnt;
                  plan.bytes = code_le.bytes;
                end else begin
                  plan.cnt   = code_be.cnt;
                  plan.bytes = code_be.bytes;
                end
              end
            end
          endcase
        end
      end
    endcase
    plan.enc = enc_next;
  end

  assign push = accept && !stopped && (plan.cnt != 2'd0);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= BOM_START;
      enc     <= ENC_ANSI;
      rem     <= 2'd0;
      acc     <= '0;
      saved   <= 8'd0;
      stopped <= 1'b0;
    end else if (accept && !stopped) begin
      phase   <= phase_next;
      enc     <= enc_next;
      rem     <= rem_next;
      acc     <= acc_next;
      saved   <= saved_next;
      stopped <= plan.fin;
    end
  end

endmodule
`default_nettype wire

/* rtl/bomut_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module bomut_fifo
  import bomut_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire plan_t push_plan,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output plan_t      head
);

  plan_t      entries [QueueLen];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(QueueLen));
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_plan;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/bomut_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module bomut_back
  import bomut_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  avail,
  input  wire plan_t head,
  input  wire logic  take,
  output logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       stream_end,
  output logic       error,
  output enc_t       encoding
);

  logic [1:0] idx;
  logic       is_fin;

  assign last   = (idx == head.cnt - 2'd1);
  assign is_fin = head.fin && last;
  assign pop    = avail && take && last;

  // current result of the head entry
  always_comb begin
    case (idx)
      2'd1:    out_byte = head.bytes[1];
      2'd2:    out_byte = head.bytes[2];
      default: out_byte = head.bytes[0];
    endcase
    if (is_fin) begin
      out_byte = 8'd0;
    end
  end

  assign byte_valid = !is_fin;
  assign stream_end = is_fin;
  assign error      = is_fin && head.err;
  assign encoding   = head.enc;

  // result index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (avail && take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

/* rtl/bom_utf_transcoder_to_utf8_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Byte order mark detection and transcoding of a text byte stream to UTF-8.
// Input channel s_*: one raw byte per request, or an end-of-input mark
// (s_tuser). The first bytes select ANSI, UTF-8, UTF-16LE or UTF-16BE.
// Output channel m_*: one result per request: an output byte, or the single
// stream-end result (error flagged for a bad lead or a cut-off sequence).
// m_tlast marks the last result caused by one input request.
// The front stage decodes a byte in the cycle it is accepted and writes up
// to three results into a two-entry queue; the results are registered in
// the queue before they appear on m_*. The back stage sends one result per
// cycle while m_tready is high; an input byte yields up to three results
// (a UTF-16 unit gives at most three UTF-8 bytes), and bytes that only
// advance a mark or a sequence yield none. s_tready is high while the queue
// has room, so input keeps flowing while m_tready is low until both queue
// entries are full. After the stream stops all input is accepted and
// dropped. Synchronous reset empties the queue and restarts detection.
module bom_utf_transcoder_to_utf8_unit
  import bomut_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tuser,   // [0] end_of_input
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [4:0]      m_tuser,   // [0] byte_valid [1] stream_end [2] error [4:3] encoding
  output logic            m_tlast
);

  logic  q_full, q_empty, push, pop;
  plan_t push_plan, head;
  logic  byte_valid, stream_end, error;
  enc_t  encoding;

  assign s_tready = !q_full;
  assign m_tvalid = !q_empty;

  // front: mark detection and decoding
  bomut_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (s_tvalid && s_tready),
    .in_byte      (s_tdata),
    .end_of_input (s_tuser),
    .push         (push),
    .plan         (push_plan)
  );

  // queue between the two sides
  bomut_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // back: one result per cycle while m_tready is high
  bomut_back u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (!q_empty),
    .head       (head),
    .take       (m_tready),
    .pop        (pop),
    .out_byte   (m_tdata),
    .byte_valid (byte_valid),
    .last       (m_tlast),
    .stream_end (stream_end),
    .error      (error),
    .encoding   (encoding)
  );

  assign m_tuser = {encoding, error, stream_end, byte_valid};

  // stream end always closes the results of its request
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("stream end result not marked last");

  // an error only comes with the stream end result
  a_err_with_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1] && !m_tuser[0]))
    else $error("error flag without stream end");

  // nothing follows the stream end
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[1]) |=> !m_tvalid)
    else $error("result after stream end");

endmodule
`default_nettype wire
